[design/spst_pkg.sv]
// Package of shared widths, types and register codes for the stroke point smoother.
`default_nettype none
package spst_pkg;

   localparam int COORD_WIDTH  = 24;
   localparam int COUNT_WIDTH  = 16;
   localparam int WEIGHT_WIDTH = 16;
   localparam int THRESH_WIDTH = 23;

   localparam int CSR_DATA_WIDTH  = (WEIGHT_WIDTH > THRESH_WIDTH) ? WEIGHT_WIDTH : THRESH_WIDTH;
   localparam int CSR_INDEX_WIDTH = 1;

   // Difference of two coordinates, and the product of that with the weight.
   localparam int DIFF_WIDTH = COORD_WIDTH + 1;
   localparam int PROD_WIDTH = DIFF_WIDTH + WEIGHT_WIDTH + 1;
   localparam int CMP_WIDTH  = (DIFF_WIDTH > THRESH_WIDTH) ? DIFF_WIDTH : THRESH_WIDTH;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [COUNT_WIDTH-1:0]        count_type;
   typedef logic [WEIGHT_WIDTH-1:0]       weight_type;
   typedef logic [THRESH_WIDTH-1:0]       thresh_type;
   typedef logic [CSR_INDEX_WIDTH-1:0]    csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]     csr_data_type;

   localparam csr_index_type CSR_SMOOTH_WEIGHT  = csr_index_type'(0);
   localparam csr_index_type CSR_THIN_THRESHOLD = csr_index_type'(1);

   localparam weight_type WEIGHT_RESET = weight_type'(32768);
   localparam thresh_type THRESH_RESET = thresh_type'(256);

   // Control sent from the top level to each axis slice.
   typedef struct packed {
      logic advance;   // the item in the input register moves to the result register
      logic first;     // the item is the first point of its stroke
      logic keep;      // the item survives thinning on either axis
   } axis_ctrl_type;

endpackage
`default_nettype wire

[design/spst_channels.sv]
// Valid/ready channel interfaces for pen points in and smoothed points out.
`default_nettype none
interface spst_req_if;
   import spst_pkg::*;
   logic      valid;
   logic      ready;
   coord_type x_coord;
   coord_type y_coord;
   logic      new_stroke;

   modport source (output valid, output x_coord, output y_coord, output new_stroke,
                   input ready);
   modport sink   (input valid, input x_coord, input y_coord, input new_stroke,
                   output ready);
endinterface

interface spst_rsp_if;
   import spst_pkg::*;
   logic      valid;
   logic      ready;
   coord_type smooth_x;
   coord_type smooth_y;
   logic      keep;
   count_type point_index;

   modport source (output valid, output smooth_x, output smooth_y, output keep,
                   output point_index, input ready);
   modport sink   (input valid, input smooth_x, input smooth_y, input keep,
                   input point_index, output ready);
endinterface
`default_nettype wire

[design/spst_axis.sv]
// One axis of the smoother: moving average, thinning distance test and axis state.
`default_nettype none
module spst_axis (
   input  wire                     clock,
   input  wire                     reset,
   input  spst_pkg::axis_ctrl_type ctrl,
   input  spst_pkg::coord_type     raw,
   input  spst_pkg::weight_type    weight,
   input  spst_pkg::thresh_type    threshold,
   output spst_pkg::coord_type     smooth,
   output logic                    far
);
   import spst_pkg::*;

   coord_type                     prev_ff, prev_in;
   coord_type                     kept_ff, kept_in;
   logic signed [DIFF_WIDTH-1:0]   hist_diff;
   logic signed [WEIGHT_WIDTH:0]   weight_s;
   logic signed [PROD_WIDTH-1:0]   product;
   logic [DIFF_WIDTH:0]            blended;
   logic [DIFF_WIDTH-1:0]          kept_diff;
   logic [DIFF_WIDTH-1:0]          magnitude;
   logic [CMP_WIDTH-1:0]           magnitude_cmp;
   logic [CMP_WIDTH-1:0]           threshold_cmp;

   // w*prev + (1-w)*raw equals raw*2^16 + w*(prev-raw), so one multiply suffices
   // and the floor shift becomes an arithmetic shift of the product.
   assign hist_diff = {prev_ff[COORD_WIDTH-1], prev_ff} - {raw[COORD_WIDTH-1], raw};
   assign weight_s  = signed'({1'b0, weight});
   assign product   = hist_diff * weight_s;
   assign blended   = product[PROD_WIDTH-1:WEIGHT_WIDTH]
                      + {{2{raw[COORD_WIDTH-1]}}, raw};
   assign smooth    = ctrl.first ? raw : coord_type'(blended[COORD_WIDTH-1:0]);

   assign kept_diff     = {raw[COORD_WIDTH-1], raw} - {kept_ff[COORD_WIDTH-1], kept_ff};
   assign magnitude     = kept_diff[DIFF_WIDTH-1] ? (~kept_diff + 1'b1) : kept_diff;
   assign magnitude_cmp = CMP_WIDTH'(magnitude);
   assign threshold_cmp = CMP_WIDTH'(threshold);
   assign far           = magnitude_cmp >= threshold_cmp;

   assign prev_in = ctrl.advance ? smooth : prev_ff;
   assign kept_in = (ctrl.advance && ctrl.keep) ? raw : kept_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         kept_ff <= '0;
      end else begin
         prev_ff <= prev_in;
         kept_ff <= kept_in;
      end
   end

endmodule
`default_nettype wire

[design/stroke_point_smooth_and_thin_core.sv]
// Top level of the stroke point smoother and thinner.
`default_nettype none
// Each accepted pen point yields exactly one result: the point smoothed on both
// axes by an exponential moving average, a keep flag from the per-axis thinning
// distance test against the last kept raw point, and the point's index within
// its stroke (saturating at its maximum). The first point of a stroke, whether
// flagged by new_stroke or the first after reset, passes through unchanged and
// is always kept. The block takes one point per clock cycle when the result
// side keeps pace. A point is held in the input register, then takes a single
// pass through one multiplier per axis, whose smoothed value is fed back to
// the next point, into the result register, from which its result is offered.
// The result register decouples the two sides, so a new point is taken while
// a finished result still waits for its transfer. The weight and threshold
// registers should be written only while no point is in flight.
module stroke_point_smooth_and_thin_core (
   input  wire                     clock,
   input  wire                     reset,
   spst_req_if.sink                req_channel,
   spst_rsp_if.source              rsp_channel,
   input  wire                     csr_write,
   input  spst_pkg::csr_index_type csr_index,
   input  spst_pkg::csr_data_type  csr_data
);
   import spst_pkg::*;

   // Configuration registers.
   weight_type weight_ff;
   thresh_type thresh_ff;

   // Input register.
   logic      in_valid_ff, in_valid_in;
   coord_type in_x_ff, in_y_ff;
   logic      in_new_ff;

   // Result register.
   logic      out_valid_ff, out_valid_in;
   coord_type out_x_ff, out_y_ff;
   logic      out_keep_ff;
   count_type out_index_ff;

   // Stroke point counter.
   count_type count_ff, count_in;

   logic          advance;
   logic          accept;
   logic          first;
   logic          keep;
   count_type     index;
   coord_type     smooth_x, smooth_y;
   logic          far_x, far_y;
   axis_ctrl_type axis_ctrl;

   // The input register empties whenever the result register is free or its
   // contents are being taken in this cycle.
   assign advance = in_valid_ff && (!out_valid_ff || rsp_channel.ready);
   assign req_channel.ready = !in_valid_ff || advance;
   assign accept = req_channel.valid && req_channel.ready;

   // A new stroke flag acts as if the counter had been cleared before this point.
   assign index = in_new_ff ? '0 : count_ff;
   assign first = (index == '0);
   assign keep  = first || far_x || far_y;

   assign axis_ctrl = '{advance: advance, first: first, keep: keep};

   spst_axis axis_x (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (axis_ctrl),
      .raw       (in_x_ff),
      .weight    (weight_ff),
      .threshold (thresh_ff),
      .smooth    (smooth_x),
      .far       (far_x)
   );

   spst_axis axis_y (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (axis_ctrl),
      .raw       (in_y_ff),
      .weight    (weight_ff),
      .threshold (thresh_ff),
      .smooth    (smooth_y),
      .far       (far_y)
   );

   always_comb begin
      count_in = count_ff;
      if (advance) begin
         count_in = (&index) ? index : index + 1'b1;
      end
   end

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_channel.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_x_ff   <= req_channel.x_coord;
         in_y_ff   <= req_channel.y_coord;
         in_new_ff <= req_channel.new_stroke;
      end
      if (advance) begin
         out_x_ff     <= smooth_x;
         out_y_ff     <= smooth_y;
         out_keep_ff  <= keep;
         out_index_ff <= index;
      end
   end

   // Configuration writes; an index outside the register list is ignored and
   // data bits above a register's width are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= WEIGHT_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SMOOTH_WEIGHT: begin
               weight_ff <= csr_data[WEIGHT_WIDTH-1:0];
            end
            CSR_THIN_THRESHOLD: begin
               thresh_ff <= csr_data[THRESH_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_channel.valid       = out_valid_ff;
   assign rsp_channel.smooth_x    = out_x_ff;
   assign rsp_channel.smooth_y    = out_y_ff;
   assign rsp_channel.keep        = out_keep_ff;
   assign rsp_channel.point_index = out_index_ff;

endmodule
`default_nettype wire

[design/spst_checker.sv]
// Port-level checker for the stroke point smoother, with its bind to the top level.
`default_nettype none
module spst_checker (
   input wire                 clock,
   input wire                 reset,
   input wire                 req_valid,
   input wire                 req_ready,
   input wire                 rsp_valid,
   input wire                 rsp_ready,
   input spst_pkg::coord_type rsp_smooth_x,
   input spst_pkg::coord_type rsp_smooth_y,
   input wire                 rsp_keep,
   input spst_pkg::count_type rsp_point_index
);
   import spst_pkg::*;

   logic req_fire;
   logic rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // A stalled result holds still.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_smooth_x)
         && $stable(rsp_smooth_y) && $stable(rsp_keep) && $stable(rsp_point_index))
   else $error("stalled result changed or vanished");

   // A point taken in must be followed by a result on offer.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |-> ##2 rsp_valid)
   else $error("no result two cycles after an input transfer");

   // The first point of a stroke is always kept.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_point_index == '0) |-> rsp_keep)
   else $error("first point of a stroke not kept");

   // Back-to-back results count up, restart a stroke, or stay at saturation.
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && $past(rsp_fire) && !$past(reset) |->
         (rsp_point_index == '0) || (rsp_point_index == $past(rsp_point_index) + 1'b1)
         || ((rsp_point_index == $past(rsp_point_index)) && (&rsp_point_index)))
   else $error("point index sequence broken");

endmodule

bind stroke_point_smooth_and_thin_core spst_checker checker_inst (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_channel.valid),
   .req_ready       (req_channel.ready),
   .rsp_valid       (rsp_channel.valid),
   .rsp_ready       (rsp_channel.ready),
   .rsp_smooth_x    (rsp_channel.smooth_x),
   .rsp_smooth_y    (rsp_channel.smooth_y),
   .rsp_keep        (rsp_channel.keep),
   .rsp_point_index (rsp_channel.point_index)
);
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the stroke point smoother and thinner core.
`timescale 1ns / 100ps
module tb;
   import spst_pkg::*;

   // Timing and run length.
   localparam int CYCLE_LIMIT      = 500000;
   localparam int SETTLE_CYCLES    = 4;
   localparam int PHASE_POINTS     = 205;
   localparam int HOLDOFF_LONG     = 300;
   localparam int FULL_RATE_POINTS = 64;

   // Coordinate and arithmetic limits, reckoned from the package widths.
   localparam longint COORD_TOP    = (longint'(1) << (COORD_WIDTH - 1)) - 1;
   localparam longint COORD_BOTTOM = -(longint'(1) << (COORD_WIDTH - 1));
   localparam longint WEIGHT_UNITY = longint'(1) << WEIGHT_WIDTH;
   localparam coord_type COORD_HI  = coord_type'(COORD_TOP);
   localparam coord_type COORD_LO  = coord_type'(COORD_BOTTOM);
   localparam weight_type WEIGHT_TOP = '1;
   localparam thresh_type THRESH_TOP = '1;

   // One smoothed point as the block should present it.
   typedef struct packed {
      coord_type smooth_x;
      coord_type smooth_y;
      logic      keep;
      count_type point_index;
   } smoothed_point_type;

   // Shadow of the smoother: it keeps its own copy of the stroke state and the
   // two registers, works out the smoothed point for every accepted pen point
   // and holds those points until the block hands its results over.
   class stroke_smoothing_scoreboard;
      weight_type         weight;
      thresh_type         threshold;
      coord_type          last_smooth_x;
      coord_type          last_smooth_y;
      coord_type          anchor_x;
      coord_type          anchor_y;
      count_type          stroke_points;
      smoothed_point_type awaited_points[$];
      int unsigned        mismatches;
      int unsigned        points_noted;
      int unsigned        points_checked;

      function new();
         weight         = WEIGHT_RESET;
         threshold      = THRESH_RESET;
         mismatches     = 0;
         points_noted   = 0;
         points_checked = 0;
         clear_stroke();
      endfunction

      function void clear_stroke();
         last_smooth_x = '0;
         last_smooth_y = '0;
         anchor_x      = '0;
         anchor_y      = '0;
         stroke_points = '0;
      endfunction

      // Bits above a register's width are simply dropped.
      function void set_register(csr_index_type reg_index, csr_data_type word);
         case (reg_index)
            CSR_SMOOTH_WEIGHT:  weight    = word[WEIGHT_WIDTH-1:0];
            CSR_THIN_THRESHOLD: threshold = word[THRESH_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      // Weighted blend of history and the raw value; the arithmetic shift of a
      // signed sum rounds towards minus infinity, as the block truncates.
      function coord_type blend(coord_type history, coord_type raw);
         longint w;
         longint acc;
         w   = longint'(weight);
         acc = w * longint'(history) + (WEIGHT_UNITY - w) * longint'(raw);
         return coord_type'(acc >>> WEIGHT_WIDTH);
      endfunction

      function void note_pen_point(coord_type x, coord_type y, logic fresh);
         smoothed_point_type p;
         longint dx;
         longint dy;
         if (fresh) clear_stroke();
         p.point_index = stroke_points;
         if (stroke_points == '0) begin
            p.smooth_x = x;
            p.smooth_y = y;
            p.keep     = 1'b1;
         end else begin
            p.smooth_x = blend(last_smooth_x, x);
            p.smooth_y = blend(last_smooth_y, y);
            dx = longint'(x) - longint'(anchor_x);
            dy = longint'(y) - longint'(anchor_y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            p.keep = (dx >= longint'(threshold)) || (dy >= longint'(threshold));
         end
         last_smooth_x = p.smooth_x;
         last_smooth_y = p.smooth_y;
         if (p.keep) begin
            anchor_x = x;
            anchor_y = y;
         end
         if (stroke_points != '1) stroke_points++;
         awaited_points.push_back(p);
         points_noted++;
      endfunction

      function void check_smoothed_point(smoothed_point_type got);
         smoothed_point_type want;
         points_checked++;
         if (awaited_points.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] result x=%0d y=%0d keep=%0b index=%0d arrived with none awaited",
                        $realtime, $signed(got.smooth_x), $signed(got.smooth_y), got.keep,
                        got.point_index);
            return;
         end
         want = awaited_points.pop_front();
         if (got.smooth_x !== want.smooth_x || got.smooth_y !== want.smooth_y ||
             got.keep !== want.keep || got.point_index !== want.point_index) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] result %0d: want x=%0d y=%0d keep=%0b index=%0d,",
                        $realtime, points_checked, $signed(want.smooth_x),
                        $signed(want.smooth_y), want.keep, want.point_index);
               $display("         got x=%0d y=%0d keep=%0b index=%0d",
                        $signed(got.smooth_x), $signed(got.smooth_y), got.keep,
                        got.point_index);
            end
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          csr_write;
   csr_index_type csr_index;
   csr_data_type  csr_data;

   spst_req_if req_bus ();
   spst_rsp_if rsp_bus ();

   stroke_smoothing_scoreboard stroke_shadow;

   // Idling controls shared between the stimulus and the result receiver.
   bit          tx_idle_on;
   bit          rx_idle_on;
   int unsigned holdoff_request;
   int unsigned cycle_count;
   int unsigned settings_count;

   stroke_point_smooth_and_thin_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_bus),
      .rsp_channel (rsp_bus),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Everything the block sees is settled well away from the rising edge, so
   // both transfer monitors sample the values that held just before it.
   initial begin
      reset              = 1'b1;
      csr_write          = 1'b0;
      csr_index          = CSR_SMOOTH_WEIGHT;
      csr_data           = '0;
      req_bus.valid      = 1'b0;
      req_bus.x_coord    = '0;
      req_bus.y_coord    = '0;
      req_bus.new_stroke = 1'b0;
      tx_idle_on         = 1'b1;
      rx_idle_on         = 1'b1;
      holdoff_request    = 0;
      cycle_count        = 0;
      settings_count     = 0;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Transfer monitor. The pen point is noted before the result is checked, so
   // the ordering holds even if a result could leave in the cycle its point
   // arrived.
   always @(posedge clock) begin
      smoothed_point_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            stroke_shadow.note_pen_point(req_bus.x_coord, req_bus.y_coord,
                                         req_bus.new_stroke);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.smooth_x    = rsp_bus.smooth_x;
            got.smooth_y    = rsp_bus.smooth_y;
            got.keep        = rsp_bus.keep;
            got.point_index = rsp_bus.point_index;
            stroke_shadow.check_smoothed_point(got);
         end
      end
   end

   // Result receiver. Before each result it may hold ready low for a few
   // cycles; a long hold-off requested by the stimulus replaces that draw once
   // and is counted out here, while the sender keeps offering points.
   initial begin : result_receiver
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_request != 0) begin
            stall           = holdoff_request;
            holdoff_request = 0;
         end else begin
            stall = rx_idle_on ? $urandom_range(0, 7) : 0;
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   // Offers one pen point and returns at the rising edge of its transfer.
   // With no gap drawn, valid simply stays high while the payload changes.
   task automatic send_point(coord_type x, coord_type y, logic fresh);
      int unsigned gap;
      gap = tx_idle_on ? $urandom_range(0, 7) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.x_coord    <= x;
      req_bus.y_coord    <= y;
      req_bus.new_stroke <= fresh;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // The sender stops until every smoothed point has come back, then allows
   // the pipeline a few more cycles to fall quiet.
   task automatic drain_points();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (stroke_shadow.awaited_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type reg_index, csr_data_type word);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= reg_index;
      csr_data  <= word;
      @(negedge clock);
      csr_write <= 1'b0;
      stroke_shadow.set_register(reg_index, word);
   endtask

   // Both registers are rewritten only once the block is idle. The bits above
   // the weight's width carry random rubbish, which the block must drop.
   task automatic apply_settings(weight_type w, thresh_type t);
      csr_data_type word;
      drain_points();
      word = csr_data_type'($urandom);
      word[WEIGHT_WIDTH-1:0] = w;
      write_register(CSR_SMOOTH_WEIGHT, word);
      write_register(CSR_THIN_THRESHOLD, csr_data_type'(t));
      settings_count++;
   endtask

   // A coordinate anywhere in range, hard against either end, or near zero.
   function automatic coord_type random_coord();
      case ($urandom_range(0, 3))
         0:       return coord_type'($urandom);
         1:       return coord_type'(COORD_TOP - longint'($urandom_range(0, 3)));
         2:       return coord_type'(COORD_BOTTOM + longint'($urandom_range(0, 3)));
         default: return coord_type'(longint'($urandom_range(0, 8191)) - 4096);
      endcase
   endfunction

   // One step of a pen walk, clamped to the coordinate range.
   function automatic coord_type nudge_coord(coord_type at, int unsigned reach);
      longint v;
      v = longint'(at) + longint'($urandom_range(0, 2 * reach)) - longint'(reach);
      if (v > COORD_TOP) v = COORD_TOP;
      else if (v < COORD_BOTTOM) v = COORD_BOTTOM;
      return coord_type'(v);
   endfunction

   // Mostly well-formed strokes: a new_stroke flag on the first point and a
   // random walk whose step is sized against the thinning distance, so that
   // both kept and dropped points turn up. Now and then a stroke starts with
   // no flag, a flag lands mid-stroke, or the pen jumps anywhere.
   task automatic run_stroke_phase(int unsigned n_points);
      int unsigned sent;
      int unsigned len;
      int unsigned reach;
      int unsigned i;
      coord_type   x;
      coord_type   y;
      logic        fresh;
      sent = 0;
      while (sent < n_points) begin
         len = $urandom_range(1, 40);
         x   = random_coord();
         y   = random_coord();
         case ($urandom_range(0, 2))
            0:       reach = int'(stroke_shadow.threshold) / 2 + 1;
            1:       reach = 2 * int'(stroke_shadow.threshold) + 2;
            default: reach = $urandom_range(1, 65536);
         endcase
         if (reach > (1 << 23)) reach = 1 << 23;
         for (i = 0; i < len && sent < n_points; i++) begin
            if (i != 0) begin
               if ($urandom_range(0, 19) == 0) begin
                  x = random_coord();
                  y = random_coord();
               end else begin
                  x = nudge_coord(x, reach);
                  y = nudge_coord(y, reach);
               end
            end
            fresh = (i == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 49) == 0);
            send_point(x, y, fresh);
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      int        phase;
      int        i;
      coord_type x;
      coord_type y;

      stroke_shadow = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed points under the reset settings. The very first point after
      // reset carries no flag and must still pass straight through.
      send_point(COORD_HI, COORD_HI, 1'b0);
      send_point(COORD_LO, COORD_LO, 1'b0);
      send_point(COORD_LO, COORD_HI, 1'b0);
      send_point(coord_type'(0), coord_type'(0), 1'b0);
      send_point(coord_type'(1), coord_type'(-1), 1'b0);
      // Exactly the thinning distance keeps a point, one short of it does not.
      send_point(coord_type'(256), coord_type'(0), 1'b0);
      send_point(coord_type'(511), coord_type'(0), 1'b0);
      send_point(coord_type'(-5), coord_type'(-7), 1'b1);
      send_point(coord_type'(-4), coord_type'(250), 1'b0);

      // Zero weight passes the raw point; zero distance keeps everything.
      apply_settings('0, '0);
      send_point(coord_type'(100), coord_type'(200), 1'b1);
      send_point(coord_type'(100), coord_type'(200), 1'b0);
      send_point(COORD_LO, COORD_HI, 1'b0);
      send_point(COORD_HI, COORD_LO, 1'b0);

      // Largest weight is nearly all history; largest distance keeps only the
      // widest jumps, and exactly that distance still keeps.
      apply_settings(WEIGHT_TOP, THRESH_TOP);
      send_point(COORD_HI, COORD_LO, 1'b1);
      send_point(COORD_LO, COORD_HI, 1'b0);
      send_point(coord_type'(0), coord_type'(0), 1'b0);
      send_point(COORD_HI, coord_type'(0), 1'b0);
      send_point(coord_type'(1), coord_type'(-1), 1'b0);
      send_point(coord_type'(-1), coord_type'(-1), 1'b0);
      send_point(COORD_LO, COORD_LO, 1'b0);

      // One stroke at full rate on both sides: points go in and results come
      // out back to back, each smoothed against the one just before it.
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      apply_settings(weight_type'($urandom), thresh_type'($urandom_range(0, 1023)));
      x = random_coord();
      y = random_coord();
      for (i = 0; i < FULL_RATE_POINTS; i++) begin
         send_point(x, y, i == 0);
         x = nudge_coord(x, 512);
         y = nudge_coord(y, 512);
      end
      send_point(random_coord(), random_coord(), 1'b1);

      // Random strokes under several settings, each phase with its own idling.
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_settings(weight_type'($urandom), thresh_type'($urandom_range(0, 2047)));
            1: apply_settings('0, '0);
            2: apply_settings(WEIGHT_TOP, THRESH_TOP);
            3: apply_settings(weight_type'(1), thresh_type'(1));
            4: apply_settings(weight_type'($urandom), thresh_type'($urandom));
            default: apply_settings(WEIGHT_TOP - 1'b1, thresh_type'($urandom_range(0, 65535)));
         endcase
         tx_idle_on = (phase != 1) && (phase != 4);
         rx_idle_on = (phase != 3) && (phase != 4);
         if (phase == 3) begin
            // Long hold-off on the result side while points keep coming at full
            // rate, so the block fills up and must refuse its input.
            tx_idle_on      = 1'b0;
            holdoff_request = HOLDOFF_LONG;
            for (i = 0; i < 40; i++)
               send_point(random_coord(), random_coord(), $urandom_range(0, 3) == 0);
            tx_idle_on = 1'b1;
         end
         run_stroke_phase(PHASE_POINTS);
      end

      drain_points();
      repeat (8) @(posedge clock);

      $display("Checked %0d smoothed points against %0d pen points, %0d register settings,",
               stroke_shadow.points_checked, stroke_shadow.points_noted, settings_count);
      $display("including weight and distance extremes, a full-rate stroke and a long stall.");
      if (stroke_shadow.mismatches == 0 && stroke_shadow.awaited_points.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatching results", stroke_shadow.mismatches);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[stroke_point_smooth_and_thin_core.f]
design/spst_pkg.sv
design/spst_channels.sv
design/spst_axis.sv
design/stroke_point_smooth_and_thin_core.sv
design/spst_checker.sv
tb/tb.sv
